>>> hw/rtl/mse_pkg.sv
// Package with shared constants, opcode names and the execute result record.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int NUM_REGS        = 32;
    localparam int REG_AW          = $clog2(NUM_REGS);
    localparam int MEM_WORDS       = 1024;
    localparam int MEM_AW          = $clog2(MEM_WORDS);
    localparam int PROGRAM_LINES   = 1024;
    localparam int LINE_W          = $clog2(PROGRAM_LINES + 1);
    localparam int TARGET_W        = 10;
    localparam int DATA_W          = 32;
    localparam logic [DATA_W-1:0] DATA_BASE_RESET = 32'h1001_0000;

    typedef enum logic [3:0] {
        MODE_ADD  = 4'd0,
        MODE_ADDI = 4'd1,
        MODE_SUB  = 4'd2,
        MODE_SUBI = 4'd3,
        MODE_BNE  = 4'd4,
        MODE_BLE  = 4'd5,
        MODE_BEQ  = 4'd6,
        MODE_J    = 4'd7,
        MODE_LI   = 4'd8,
        MODE_LW   = 4'd9,
        MODE_SW   = 4'd10
    } mode_t;

    typedef struct packed {
        logic [LINE_W-1:0] next_line;
        logic              taken;
        logic              wr;
        logic [REG_AW-1:0] rd;
        logic [DATA_W-1:0] value;
        logic              load;
        logic              store;
        logic              err;
        logic [MEM_AW-1:0] mem_addr;
        logic [DATA_W-1:0] store_data;
    } exec_res_t;

endpackage

>>> hw/rtl/mips_subset_execute.sv
// Top level: operand stage, execute into the result register, register file and data memory.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_valid/s_ready    one decoded instruction per beat
//  m_*       out        m_valid/m_ready    next line and register write per beat
//  cfg_*     in         cfg_wr_en          data_base, written while cfg_wr_en is high
//
// One beat is accepted per cycle while s_ready is high; each result passes the operand stage and the result register.
// The register file read and the data memory read are each registered.
// After reset all 1024 words of the data memory are cleared in turn, with s_ready low meanwhile.
// When m_ready is low the result and operand stages hold and s_ready drops once both are full.
`timescale 1ns / 1ps

module mips_subset_execute (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [31:0]                       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [3:0]                        s_mode,
    input  logic [4:0]                        s_dest_reg,
    input  logic [4:0]                        s_src_reg,
    input  logic [4:0]                        s_src2_reg,
    input  logic signed [31:0]                s_immediate,
    input  logic [9:0]                        s_target_line,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [10:0]                       m_next_line,
    output logic                              m_branch_taken,
    output logic                              m_reg_written,
    output logic [4:0]                        m_written_reg,
    output logic signed [31:0]                m_written_value,
    output logic                              m_access_error
);
    import mse_pkg::*;

    logic [DATA_W-1:0]   data_base_reg;
    logic [LINE_W-1:0]   line_counter_reg;

    logic                s1_valid_reg;
    logic [3:0]          s1_mode_reg;
    logic [REG_AW-1:0]   s1_dest_idx_reg;
    logic [REG_AW-1:0]   s1_src_idx_reg;
    logic [REG_AW-1:0]   s1_sec_idx_reg;
    logic [DATA_W-1:0]   s1_imm_reg;
    logic [TARGET_W-1:0] s1_target_reg;
    logic                byp_b_v_reg;
    logic [DATA_W-1:0]   byp_b_val_reg;
    logic                byp_x_v_reg;
    logic [DATA_W-1:0]   byp_x_val_reg;

    logic                s2_valid_reg;
    logic [LINE_W-1:0]   s2_next_line_reg;
    logic                s2_taken_reg;
    logic                s2_wr_reg;
    logic [REG_AW-1:0]   s2_rd_reg;
    logic [DATA_W-1:0]   s2_value_reg;
    logic                s2_load_reg;
    logic                s2_err_reg;

    logic                clear_done;
    logic                s_fire;
    logic                m_fire;
    logic                s2_free;
    logic                s1_advance;
    logic                commit;
    logic [REG_AW-1:0]   sec_idx;
    logic [DATA_W-1:0]   rf_data_b;
    logic [DATA_W-1:0]   rf_data_x;
    logic [DATA_W-1:0]   dmem_rdata;
    logic [DATA_W-1:0]   s2_out_value;
    logic [DATA_W-1:0]   op_b;
    logic [DATA_W-1:0]   op_x;
    exec_res_t           res;

    assign s2_free    = !s2_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && s2_free;
    assign s_ready    = clear_done && (!s1_valid_reg || s2_free);
    assign s_fire     = s_valid && s_ready;
    assign m_fire     = s2_valid_reg && m_ready;
    assign commit     = m_fire && s2_wr_reg;

    assign sec_idx = (s_mode == MODE_ADD || s_mode == MODE_SUB) ? s_src2_reg : s_dest_reg;

    assign s2_out_value = (s2_wr_reg && s2_load_reg) ? dmem_rdata : s2_value_reg;

    // The pending result in the output stage is newer than any committed write.
    always_comb begin
        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_src_idx_reg) begin
            op_b = s2_out_value;
        end else if (byp_b_v_reg) begin
            op_b = byp_b_val_reg;
        end else begin
            op_b = rf_data_b;
        end
        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_sec_idx_reg) begin
            op_x = s2_out_value;
        end else if (byp_x_v_reg) begin
            op_x = byp_x_val_reg;
        end else begin
            op_x = rf_data_x;
        end
    end

    mse_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_fire),
        .rd_addr0 (s_src_reg),
        .rd_addr1 (sec_idx),
        .rd_data0 (rf_data_b),
        .rd_data1 (rf_data_x),
        .wr_en    (commit),
        .wr_addr  (s2_rd_reg),
        .wr_data  (s2_out_value)
    );

    mse_exec u_exec (
        .mode      (s1_mode_reg),
        .dest_idx  (s1_dest_idx_reg),
        .op_b      (op_b),
        .op_x      (op_x),
        .imm       (s1_imm_reg),
        .target    (s1_target_reg),
        .line_cnt  (line_counter_reg),
        .data_base (data_base_reg),
        .res       (res)
    );

    mse_dmem u_dmem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_done (clear_done),
        .rd_en      (s1_advance && res.load),
        .wr_en      (s1_advance && res.store),
        .addr       (res.mem_addr),
        .wr_data    (res.store_data),
        .rd_data    (dmem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_base_reg    <= DATA_BASE_RESET;
            line_counter_reg <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            byp_b_v_reg      <= 1'b0;
            byp_x_v_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                data_base_reg <= cfg_wr_data;
            end

            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end

            // Writes that land after the register file read are caught here.
            if (s_fire) begin
                byp_b_v_reg <= commit && (s2_rd_reg == s_src_reg);
                byp_x_v_reg <= commit && (s2_rd_reg == sec_idx);
            end else if (commit) begin
                if (s2_rd_reg == s1_src_idx_reg) begin
                    byp_b_v_reg <= 1'b1;
                end
                if (s2_rd_reg == s1_sec_idx_reg) begin
                    byp_x_v_reg <= 1'b1;
                end
            end

            if (s1_advance) begin
                s2_valid_reg     <= 1'b1;
                line_counter_reg <= res.next_line;
            end else if (m_fire) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_mode_reg     <= s_mode;
            s1_dest_idx_reg <= s_dest_reg;
            s1_src_idx_reg  <= s_src_reg;
            s1_sec_idx_reg  <= sec_idx;
            s1_imm_reg      <= s_immediate;
            s1_target_reg   <= s_target_line;
        end
        if (s_fire ? (commit && s2_rd_reg == s_src_reg)
                   : (commit && s2_rd_reg == s1_src_idx_reg)) begin
            byp_b_val_reg <= s2_out_value;
        end
        if (s_fire ? (commit && s2_rd_reg == sec_idx)
                   : (commit && s2_rd_reg == s1_sec_idx_reg)) begin
            byp_x_val_reg <= s2_out_value;
        end
        if (s1_advance) begin
            s2_next_line_reg <= res.next_line;
            s2_taken_reg     <= res.taken;
            s2_wr_reg        <= res.wr;
            s2_rd_reg        <= res.rd;
            s2_value_reg     <= res.value;
            s2_load_reg      <= res.load;
            s2_err_reg       <= res.err;
        end
    end

    assign m_valid         = s2_valid_reg;
    assign m_next_line     = s2_next_line_reg;
    assign m_branch_taken  = s2_taken_reg;
    assign m_reg_written   = s2_wr_reg;
    assign m_written_reg   = s2_rd_reg;
    assign m_written_value = s2_out_value;
    assign m_access_error  = s2_err_reg;

    a_no_write_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_written |-> m_written_reg == '0 && m_written_value == '0)
        else $error("result without a register write carries nonzero fields");

    a_reg_zero_never_written: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_written |-> m_written_reg != '0)
        else $error("register zero reported as written");

    a_error_is_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_access_error |-> !m_reg_written && !m_branch_taken)
        else $error("access error together with a write or a branch");

    a_line_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_next_line <= LINE_W'(PROGRAM_LINES))
        else $error("next line beyond the program end");

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done |-> !s_fire && !s1_valid_reg)
        else $error("beat accepted while data memory is being cleared");

endmodule

>>> hw/rtl/mse_regfile.sv
// Register file with two registered read ports, one write port and per-entry valid bits.
`timescale 1ns / 1ps

module mse_regfile (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [mse_pkg::REG_AW-1:0] rd_addr0,
    input  logic [mse_pkg::REG_AW-1:0] rd_addr1,
    output logic [mse_pkg::DATA_W-1:0] rd_data0,
    output logic [mse_pkg::DATA_W-1:0] rd_data1,
    input  logic                      wr_en,
    input  logic [mse_pkg::REG_AW-1:0] wr_addr,
    input  logic [mse_pkg::DATA_W-1:0] wr_data
);
    import mse_pkg::*;

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0]   rdata0_reg;
    logic [DATA_W-1:0]   rdata1_reg;
    logic                rvalid0_reg;
    logic                rvalid1_reg;

    // An entry that was never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata0_reg  <= mem[rd_addr0];
            rdata1_reg  <= mem[rd_addr1];
            rvalid0_reg <= valid_reg[rd_addr0];
            rvalid1_reg <= valid_reg[rd_addr1];
        end
    end

    assign rd_data0 = rvalid0_reg ? rdata0_reg : '0;
    assign rd_data1 = rvalid1_reg ? rdata1_reg : '0;

endmodule

>>> hw/rtl/mse_dmem.sv
// Data memory with registered read and a clearing sweep after reset.
`timescale 1ns / 1ps

module mse_dmem (
    input  logic                      aclk,
    input  logic                      aresetn,
    output logic                      clear_done,
    input  logic                      rd_en,
    input  logic                      wr_en,
    input  logic [mse_pkg::MEM_AW-1:0] addr,
    input  logic [mse_pkg::DATA_W-1:0] wr_data,
    output logic [mse_pkg::DATA_W-1:0] rd_data
);
    import mse_pkg::*;

    logic [DATA_W-1:0] mem [MEM_WORDS];
    logic [DATA_W-1:0] rdata_reg;
    logic              clr_busy_reg;
    logic [MEM_AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == MEM_AW'(MEM_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign clear_done = !clr_busy_reg;
    assign rd_data    = rdata_reg;

endmodule

>>> hw/rtl/mse_exec.sv
// Execute logic: arithmetic, branch decision, next line and data address check.
`timescale 1ns / 1ps

module mse_exec (
    input  logic [3:0]                   mode,
    input  logic [mse_pkg::REG_AW-1:0]   dest_idx,
    input  logic [mse_pkg::DATA_W-1:0]   op_b,
    input  logic [mse_pkg::DATA_W-1:0]   op_x,
    input  logic [mse_pkg::DATA_W-1:0]   imm,
    input  logic [mse_pkg::TARGET_W-1:0] target,
    input  logic [mse_pkg::LINE_W-1:0]   line_cnt,
    input  logic [mse_pkg::DATA_W-1:0]   data_base,
    output mse_pkg::exec_res_t           res
);
    import mse_pkg::*;

    localparam int OFF_W = DATA_W - 2;
    localparam logic [OFF_W-1:0] MEM_LIMIT = OFF_W'(MEM_WORDS);

    logic [DATA_W-1:0] ea;
    logic [DATA_W-1:0] diff;
    logic              oob;
    logic [LINE_W-1:0] next_line;
    logic              taken;
    logic              wr_raw;
    logic              wr_ok;
    logic [DATA_W-1:0] val;
    logic              is_lw;
    logic              is_sw;

    always_comb begin
        ea   = op_b + imm;
        diff = ea - data_base;
        oob  = (ea < data_base) || (diff[DATA_W-1:2] >= MEM_LIMIT);

        taken  = 1'b0;
        wr_raw = 1'b0;
        val    = '0;
        is_lw  = 1'b0;
        is_sw  = 1'b0;
        case (mode)
            MODE_ADD: begin
                val    = op_b + op_x;
                wr_raw = 1'b1;
            end
            MODE_ADDI: begin
                val    = op_b + imm;
                wr_raw = 1'b1;
            end
            MODE_SUB: begin
                val    = op_b - op_x;
                wr_raw = 1'b1;
            end
            MODE_SUBI: begin
                val    = op_b - imm;
                wr_raw = 1'b1;
            end
            MODE_BNE: taken = (op_x != op_b);
            MODE_BLE: taken = ($signed(op_x) <= $signed(op_b));
            MODE_BEQ: taken = (op_x == op_b);
            MODE_J:   taken = 1'b1;
            MODE_LI: begin
                val    = imm;
                wr_raw = 1'b1;
            end
            MODE_LW: begin
                is_lw  = 1'b1;
                wr_raw = !oob;
            end
            MODE_SW: is_sw = 1'b1;
            default: ;
        endcase

        if (taken) begin
            next_line = LINE_W'(target);
        end else if (line_cnt >= LINE_W'(PROGRAM_LINES)) begin
            next_line = LINE_W'(PROGRAM_LINES);
        end else begin
            next_line = line_cnt + 1'b1;
        end

        wr_ok = wr_raw && (dest_idx != '0);

        res.next_line  = next_line;
        res.taken      = taken;
        res.wr         = wr_ok;
        res.rd         = wr_ok ? dest_idx : '0;
        res.value      = wr_ok ? val : '0;
        res.load       = is_lw && !oob;
        res.store      = is_sw && !oob;
        res.err        = (is_lw || is_sw) && oob;
        res.mem_addr   = diff[MEM_AW+1:2];
        res.store_data = op_x;
    end

endmodule

>>> tb/tb_mips_subset_execute.sv
// Self-checking testbench for mips_subset_execute with a built-in instruction predictor.
`timescale 1ns / 1ps

module tb_mips_subset_execute;
    import mse_pkg::*;

    localparam logic [3:0] MODE_OTHER_LO = 4'd11;
    localparam logic [3:0] MODE_OTHER_HI = 4'd15;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 325;

    typedef struct packed {
        logic [3:0]         mode;
        logic [4:0]         rd;
        logic [4:0]         rs;
        logic [4:0]         rt;
        logic signed [31:0] imm;
        logic [9:0]         target;
    } instr_t;

    typedef struct packed {
        logic [10:0] next_line;
        logic        taken;
        logic        wr;
        logic [4:0]  wreg;
        logic [31:0] wval;
        logic        err;
    } exec_out_t;

    typedef struct {
        instr_t    ins;
        bit        typed;
        exec_out_t res;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [3:0]         s_mode;
    logic [4:0]         s_dest_reg;
    logic [4:0]         s_src_reg;
    logic [4:0]         s_src2_reg;
    logic signed [31:0] s_immediate;
    logic [9:0]         s_target_line;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [10:0]        m_next_line;
    logic               m_branch_taken;
    logic               m_reg_written;
    logic [4:0]         m_written_reg;
    logic signed [31:0] m_written_value;
    logic               m_access_error;

    logic [31:0] gpr [NUM_REGS];
    logic [31:0] dmem [MEM_WORDS];
    logic [10:0] line_cnt;
    logic [31:0] pred_base;

    exec_out_t     pending_results [$];
    directed_row_t directed_rows [$];
    bit            cur_typed;
    exec_out_t     cur_typed_res;
    int            failures;
    int            burst_left;
    int            idle_cycles;
    int unsigned   ready_style;
    int unsigned   ready_left;
    int unsigned   ready_phase;

    mips_subset_execute i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_dest_reg      (s_dest_reg),
        .s_src_reg       (s_src_reg),
        .s_src2_reg      (s_src2_reg),
        .s_immediate     (s_immediate),
        .s_target_line   (s_target_line),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_line     (m_next_line),
        .m_branch_taken  (m_branch_taken),
        .m_reg_written   (m_reg_written),
        .m_written_reg   (m_written_reg),
        .m_written_value (m_written_value),
        .m_access_error  (m_access_error)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic exec_out_t execute_instr(instr_t ins);
        exec_out_t   r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] ea;
        logic [31:0] off;
        logic [31:0] val;
        logic [11:0] seq;
        logic [10:0] next;
        logic        wr;
        logic        taken;
        logic        err;
        logic        mem_ok;
        a = gpr[ins.rd];
        b = gpr[ins.rs];
        c = gpr[ins.rt];
        val = '0;
        wr = 1'b0;
        taken = 1'b0;
        err = 1'b0;
        seq = {1'b0, line_cnt} + 12'd1;
        if (seq > PROGRAM_LINES) begin
            seq = 12'(PROGRAM_LINES);
        end
        ea = b + ins.imm;
        off = (ea - pred_base) >> 2;
        mem_ok = (ea >= pred_base) && (off < MEM_WORDS);
        case (ins.mode)
            MODE_ADD: begin
                val = b + c;
                wr = 1'b1;
            end
            MODE_ADDI: begin
                val = b + ins.imm;
                wr = 1'b1;
            end
            MODE_SUB: begin
                val = b - c;
                wr = 1'b1;
            end
            MODE_SUBI: begin
                val = b - ins.imm;
                wr = 1'b1;
            end
            MODE_BNE: taken = (a != b);
            MODE_BLE: taken = ($signed(a) <= $signed(b));
            MODE_BEQ: taken = (a == b);
            MODE_J:   taken = 1'b1;
            MODE_LI: begin
                val = ins.imm;
                wr = 1'b1;
            end
            MODE_LW: begin
                if (mem_ok) begin
                    val = dmem[off[MEM_AW-1:0]];
                    wr = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            MODE_SW: begin
                if (mem_ok) begin
                    dmem[off[MEM_AW-1:0]] = a;
                end else begin
                    err = 1'b1;
                end
            end
            default: ;
        endcase
        next = taken ? {1'b0, ins.target} : seq[10:0];
        r.wreg = ins.rd;
        if (wr && ins.rd != 5'd0) begin
            gpr[ins.rd] = val;
        end else begin
            wr = 1'b0;
            val = '0;
            r.wreg = '0;
        end
        line_cnt = next;
        r.next_line = next;
        r.taken = taken;
        r.wr = wr;
        r.wval = val;
        r.err = err;
        return r;
    endfunction

    function automatic instr_t random_instr();
        instr_t      ins;
        int unsigned pick;
        int unsigned widx;
        logic [31:0] ea;
        ins.rd = $urandom_range(0, 31);
        ins.rs = $urandom_range(0, 31);
        ins.rt = $urandom_range(0, 31);
        ins.target = ($urandom_range(0, 9) == 0) ? 10'd1023 : 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 5))
            0: ins.imm = 32'h7FFF_FFFF;
            1: ins.imm = 32'h8000_0000;
            2: ins.imm = 32'hFFFF_FFFF;
            3: ins.imm = 32'($urandom_range(0, 31)) - 32'd16;
            default: ins.imm = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            ins.mode = MODE_LI;
        end else if (pick < 30) begin
            ins.mode = 4'($urandom_range(MODE_ADD, MODE_SUBI));
        end else if (pick < 45) begin
            ins.mode = 4'($urandom_range(MODE_BNE, MODE_BEQ));
            if ($urandom_range(0, 2) == 0) begin
                ins.rs = ins.rd;
            end
        end else if (pick < 49) begin
            ins.mode = MODE_J;
        end else if (pick < 52) begin
            ins.mode = 4'($urandom_range(MODE_OTHER_LO, MODE_OTHER_HI));
        end else begin
            ins.mode = ($urandom_range(0, 1) == 0) ? MODE_LW : MODE_SW;
            pick = $urandom_range(0, 9);
            widx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MEM_WORDS - 1)
                                                : $urandom_range(0, 15);
            if (pick < 7) begin
                ea = pred_base + widx * 4 + $urandom_range(0, 3);
            end else if (pick == 7) begin
                ea = pred_base - $urandom_range(1, 8);
            end else begin
                ea = pred_base + MEM_WORDS * 4 + $urandom_range(0, 7);
            end
            if (pick != 9) begin
                ins.imm = ea - gpr[ins.rs];
            end
        end
        return ins;
    endfunction

    task automatic add_row(input logic [3:0] mode, input logic [4:0] rd, input logic [4:0] rs,
                           input logic [4:0] rt, input logic [31:0] imm,
                           input logic [9:0] target, input bit typed,
                           input logic [10:0] nl, input logic tk, input logic wr,
                           input logic [4:0] wreg, input logic [31:0] wval, input logic err);
        directed_row_t row;
        row.ins = {mode, rd, rs, rt, imm, target};
        row.typed = typed;
        row.res = {nl, tk, wr, wreg, wval, err};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endtask

    // Opens the slot for the next beat, inserting a random gap, which may be empty, between bursts.
    task automatic open_slot();
        int unsigned gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic drive_instr(input instr_t ins, input bit typed, input exec_out_t res);
        s_mode = ins.mode;
        s_dest_reg = ins.rd;
        s_src_reg = ins.rs;
        s_src2_reg = ins.rt;
        s_immediate = ins.imm;
        s_target_line = ins.target;
        cur_typed = typed;
        cur_typed_res = res;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_data_base(input logic [31:0] value);
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    always @(posedge aclk) begin : monitor
        exec_out_t got;
        exec_out_t want;
        exec_out_t pred;
        int        i;
        if (!aresetn) begin
            for (i = 0; i < NUM_REGS; i++) gpr[i] = '0;
            for (i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
            line_cnt = '0;
            pred_base = DATA_BASE_RESET;
        end else begin
            if (cfg_wr_en) begin
                pred_base = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                pred = execute_instr({s_mode, s_dest_reg, s_src_reg, s_src2_reg,
                                      s_immediate, s_target_line});
                pending_results.insert(pending_results.size(),
                                       cur_typed ? cur_typed_res : pred);
            end
            if (m_valid && m_ready) begin
                got = {m_next_line, m_branch_taken, m_reg_written, m_written_reg,
                       m_written_value, m_access_error};
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("next_line", want.next_line, got.next_line);
                    check_field("branch_taken", want.taken, got.taken);
                    check_field("reg_written", want.wr, got.wr);
                    check_field("written_reg", want.wreg, got.wreg);
                    check_field("written_value", want.wval, got.wval);
                    check_field("access_error", want.err, got.err);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("mips_subset_execute verification failed");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_style = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 160);
        end else begin
            ready_left--;
        end
        ready_phase++;
        case (ready_style)
            0: m_ready = 1'b1;
            1: m_ready = ($urandom_range(0, 3) != 0);
            2: m_ready = ($urandom_range(0, 4) == 0);
            default: m_ready = (ready_phase % 7) > 2;
        endcase
    end

    initial begin
        logic [31:0] phase_bases [5];
        int          p;
        int          n;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_mode = '0;
        s_dest_reg = '0;
        s_src_reg = '0;
        s_src2_reg = '0;
        s_immediate = '0;
        s_target_line = '0;
        cur_typed = 1'b0;
        cur_typed_res = '0;
        failures = 0;
        burst_left = 0;
        phase_bases[0] = 32'h0000_0000;
        phase_bases[1] = 32'hFFFF_F000;
        phase_bases[2] = 32'hFFFF_FFFF;
        phase_bases[3] = $urandom;
        phase_bases[4] = DATA_BASE_RESET;

        add_row(MODE_LI,   1,  0,  0, 32'h7FFF_FFFF, 0, 1, 1, 0, 1, 1, 32'h7FFF_FFFF, 0);
        add_row(MODE_LI,   2,  0,  0, 32'h8000_0000, 0, 1, 2, 0, 1, 2, 32'h8000_0000, 0);
        add_row(MODE_ADD,  3,  1,  1, 0,             0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_ADDI, 4,  1,  0, 1,             0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SUB,  5,  2,  1, 0,             0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SUBI, 6,  2,  0, 1,             0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LI,   0,  0,  0, 5,             0, 1, 7, 0, 0, 0, 0, 0);
        add_row(MODE_LI,   7,  0,  0, DATA_BASE_RESET, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SW,   1,  7,  0, 0,             0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SW,   2,  7,  0, 4092,          0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LW,   8,  7,  0, 4092,          0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LW,   7,  7,  0, 0,             0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LI,  10,  0,  0, DATA_BASE_RESET - 4, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LW,   9, 10,  0, 0,             0, 1, 14, 0, 0, 0, 0, 1);
        add_row(MODE_SW,   1, 10,  0, 4100,          0, 1, 15, 0, 0, 0, 0, 1);
        add_row(MODE_LW,   9,  0,  0, 32'hFFFF_FFFC, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_BNE,  1,  2,  0, 0,          1023, 1, 1023, 1, 0, 0, 0, 0);
        add_row(MODE_ADD, 11,  1,  2, 0,             0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_OTHER_LO, 0, 0, 0, 0,           0, 1, 1024, 0, 0, 0, 0, 0);
        add_row(MODE_BLE,  2,  1,  0, 0,             0, 1, 0, 1, 0, 0, 0, 0);
        add_row(MODE_BLE,  1,  2,  0, 0,           700, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_BEQ,  1,  2,  0, 0,             9, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_BEQ,  0,  0,  0, 0,             5, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_BNE,  1,  1,  0, 0,           300, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_J,   31, 31, 31, 32'hFFFF_FFFF, 512, 1, 512, 1, 0, 0, 0, 0);
        add_row(MODE_OTHER_HI, 31, 31, 31, 32'h8000_0000, 1023, 1, 513, 0, 0, 0, 0, 0);

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            open_slot();
            drive_instr(directed_rows[i].ins, directed_rows[i].typed, directed_rows[i].res);
        end

        for (p = 0; p < 5; p++) begin
            write_data_base(phase_bases[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                open_slot();
                drive_instr(random_instr(), 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("mips_subset_execute verification clean");
        end else begin
            $display("mips_subset_execute verification failed");
        end
        $finish;
    end

endmodule
